### hw/rtl/unique_key_table_compacting_defines.svh
// assertion macros used by the checker file
`ifndef UNIQUE_KEY_TABLE_COMPACTING_DEFINES_SVH
`define UNIQUE_KEY_TABLE_COMPACTING_DEFINES_SVH

// clocked check, muted while reset is held
`define UKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define UKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ukt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ukt_pkg;

  // fixed field widths
  localparam int KEY_W = 31;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int POS_W = 6;
  localparam int TOT_W = 7;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } ukt_op_t;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

  // strobes from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } ukt_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/ukt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ukt_cell import ukt_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ukt_ctl_t         ctl,
  input  wire logic [KEY_W-1:0] search_key,
  input  wire logic [IDX_W-1:0] hit_pos,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [KEY_W-1:0] nbr_key,
  output logic      [KEY_W-1:0] slot_key,
  output logic                  match
);

  logic occupied;
  logic shift_in;
  logic load_new;

  // slot holds a live key only below the fill count
  assign occupied = CNT_W'(IDX) < count;

  // compacting move: every slot from the hit up to the one before the last
  assign shift_in = ctl.rem_en && (IDX_W'(IDX) >= hit_pos) && (CNT_W'(IDX + 1) < count);

  // append lands in the first free slot
  assign load_new = ctl.ins_en && (CNT_W'(IDX) == count);

  // stored key, written only on append or shift
  always_ff @(posedge clk) begin
    if (load_new) begin
      slot_key <= search_key;
    end else if (shift_in) begin
      slot_key <= nbr_key;
    end
  end

  // registered compare against the search key
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp_en) begin
      match <= occupied && (slot_key == search_key);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/unique_key_table_compacting.sv
`timescale 1ns / 1ps
`default_nettype none

// Packed table of up to TABLE_DEPTH unique 31-bit keys kept in insertion
// order in a row of cells. Each request (insert, find, remove, none) returns
// one result with status, slot position and the new entry count. In the
// compare state every cell compares its key in parallel and registers a
// match bit; in the result state the match position is encoded, the result
// is registered and the cells append or shift down by one slot. One request
// is in flight at a time and the block is ready again only in the cycle
// after the result is registered; a result left untaken stalls the current
// request in its result state until it is taken.
// position and entry_total are the low 6 and 7 bits of the slot and count.
module unique_key_table_compacting import ukt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [KEY_W-1:0] key_id,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [ST_W-1:0]  status,
  output logic      [POS_W-1:0] position,
  output logic      [TOT_W-1:0] entry_total
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RES
  } state_t;

  state_t                  state;
  ukt_op_t                 op_q;
  logic [KEY_W-1:0]        key_q;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  ukt_ctl_t                ctl;
  logic [TABLE_DEPTH-1:0]  match_vec;
  logic [KEY_W-1:0]        slot_keys [TABLE_DEPTH];
  logic [IDX_W-1:0]        hit_pos;
  logic                    found;
  logic                    finish;
  logic [ST_W-1:0]         st_next;
  logic [IDX_W-1:0]        pos_next;
  logic                    table_full;

  assign in_ready = (state == S_IDLE);
  assign finish   = (state == S_RES) && (!out_valid || out_ready);

  // one-hot match to slot index (keys are unique, so at most one bit set)
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_pos = hit_pos | (match_vec[i] ? IDX_W'(i) : '0);
    end
  end
  assign found      = |match_vec;
  assign table_full = (count >= CNT_W'(TABLE_DEPTH));

  // outcome of the request held in the result stage
  always_comb begin
    st_next    = ST_MISS;
    pos_next   = '0;
    count_next = count;
    ctl.cmp_en = (state == S_CMP);
    ctl.ins_en = 1'b0;
    ctl.rem_en = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (found) begin
          st_next = ST_DUP;
        end else if (table_full) begin
          st_next = ST_FULL;
        end else begin
          st_next    = ST_OK;
          pos_next   = IDX_W'(count);
          count_next = count + CNT_W'(1);
          ctl.ins_en = finish;
        end
      end
      OP_FIND: begin
        if (found) begin
          st_next  = ST_OK;
          pos_next = hit_pos;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          st_next    = ST_OK;
          pos_next   = hit_pos;
          count_next = count - CNT_W'(1);
          ctl.rem_en = finish;
        end
      end
      OP_NONE: begin
        st_next = ST_MISS;
      end
      default: begin
        st_next = ST_MISS;
      end
    endcase
  end

  // row of key cells, each shifting from its upper neighbor
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ukt_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .search_key (key_q),
      .hit_pos    (hit_pos),
      .count      (count),
      .nbr_key    (slot_keys[(g + 1 < TABLE_DEPTH) ? g + 1 : g]),
      .slot_key   (slot_keys[g]),
      .match      (match_vec[g])
    );
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q  <= ukt_op_t'(opcode);
      key_q <= key_id;
    end
  end

  // sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result valid: set when a request finishes, cleared once taken
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_RES;
        end
        S_RES: begin
          if (finish) begin
            count       <= count_next;
            status      <= st_next;
            position    <= POS_W'(pos_next);
            entry_total <= TOT_W'(count_next);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ukt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "unique_key_table_compacting_defines.svh"

module ukt_checker import ukt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic [OP_W-1:0]  opcode,
  input wire logic [KEY_W-1:0] key_id,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ST_W-1:0]  status,
  input wire logic [POS_W-1:0] position,
  input wire logic [TOT_W-1:0] entry_total
);

  // a stalled result keeps its payload
  `UKT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position) && $stable(entry_total), "result changed while stalled")

  // no result is pending right after reset
  `UKT_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result valid after reset")

  // a new transaction is not taken while one is in flight
  `UKT_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second transaction taken during work")

  // failed requests report slot zero
  `UKT_ASSERT(a_fail_pos, out_valid && status != ST_OK |-> position == '0, "nonzero position on failure")

  // table full only when the count is at capacity
  `UKT_ASSERT(a_full_count, out_valid && status == ST_FULL |-> entry_total == TOT_W'(TABLE_DEPTH), "full status with spare room")

  // the request fields are watched only through the handshake
  logic unused_ok;
  assign unused_ok = ^{opcode, key_id};

endmodule

bind unique_key_table_compacting ukt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ukt_checker (.*);

`default_nettype wire

### bench/unique_key_table_compacting_tb.sv
`timescale 1ns / 1ps

module unique_key_table_compacting_tb;
  import ukt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  // expected reply of one table transaction
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [TOT_W-1:0] total;
  } table_reply_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  opcode = '0;
  logic [KEY_W-1:0] key_id = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] position;
  logic [TOT_W-1:0] entry_total;

  // shadow copy of the key table
  logic [KEY_W-1:0] key_table [TABLE_DEPTH];
  int               key_count = 0;

  table_reply_t     pending_replies [$];
  table_reply_t     want_reply;
  int               fail_count = 0;
  int               cycle_count = 0;
  bit               calm = 1'b0;

  unique_key_table_compacting #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .key_id     (key_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .position   (position),
    .entry_total(entry_total)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // apply one request to the shadow table and return the reply it produces
  function automatic table_reply_t apply_request(ukt_op_t op, logic [KEY_W-1:0] key);
    int hit;
    table_reply_t reply;
    hit = -1;
    for (int i = 0; i < key_count; i++) begin
      if (hit < 0 && key_table[i] == key) hit = i;
    end
    reply.status = ST_MISS;
    reply.position = '0;
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          reply.status = ST_DUP;
        end else if (key_count >= TABLE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          key_table[key_count] = key;
          reply.position = POS_W'(key_count);
          key_count++;
          reply.status = ST_OK;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          reply.status = ST_OK;
          reply.position = POS_W'(hit);
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // close the gap so the table stays packed
          for (int i = hit; i + 1 < key_count; i++) key_table[i] = key_table[i + 1];
          key_count--;
          reply.status = ST_OK;
          reply.position = POS_W'(hit);
        end
      end
      default: ;
    endcase
    reply.total = TOT_W'(key_count);
    return reply;
  endfunction

  // key source: a stored key, a corner value or a fully random key
  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (key_count > 0 && roll < hit_pct) return key_table[$urandom_range(0, key_count - 1)];
    if (roll < hit_pct + 10) begin
      if ($urandom_range(0, 1)) return 31'h7FFFFFFF - KEY_W'($urandom_range(0, 3));
      return KEY_W'($urandom_range(0, 3));
    end
    return KEY_W'($urandom());
  endfunction

  // send one request transaction and record its expected reply on acceptance
  task automatic send_request(input ukt_op_t op, input logic [KEY_W-1:0] key);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    key_id <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(apply_request(op, key));
  endtask

  // hold off new requests until every reply is back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // reply checker and random backpressure
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected reply: status %0d position %0d total %0d",
                   status, position, entry_total);
      end else begin
        want_reply = pending_replies.pop_front();
        if (status !== want_reply.status || position !== want_reply.position ||
            entry_total !== want_reply.total) begin
          fail_count++;
          if (fail_count <= 10)
            $display("reply mismatch: status exp %0d got %0d, position exp %0d got %0d, %s",
                     want_reply.status, status, want_reply.position, position,
                     $sformatf("total exp %0d got %0d", want_reply.total, entry_total));
        end
      end
    end
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
  end

  // corner keys, every opcode, misses, shifts and an empty table
  task automatic test_basic_edits();
    send_request(OP_FIND, 31'h0);
    send_request(OP_REMOVE, 31'h0);
    send_request(OP_INSERT, 31'h0);
    send_request(OP_INSERT, 31'h7FFFFFFF);
    send_request(OP_INSERT, 31'h0);
    send_request(OP_INSERT, 31'h2AAAAAAA);
    send_request(OP_INSERT, 31'h55555555);
    send_request(OP_FIND, 31'h0);
    send_request(OP_FIND, 31'h7FFFFFFF);
    send_request(OP_FIND, 31'h55555555);
    send_request(OP_FIND, 31'h00001234);
    send_request(OP_NONE, 31'h2AAAAAAA);
    send_request(OP_NONE, 31'h00001234);
    send_request(OP_REMOVE, 31'h2AAAAAAA);
    send_request(OP_FIND, 31'h55555555);
    send_request(OP_REMOVE, 31'h00001234);
    send_request(OP_REMOVE, 31'h0);
    send_request(OP_FIND, 31'h7FFFFFFF);
    send_request(OP_REMOVE, 31'h7FFFFFFF);
    send_request(OP_REMOVE, 31'h55555555);
    send_request(OP_FIND, 31'h55555555);
    send_request(OP_INSERT, 31'h7FFFFFFF);
    send_request(OP_REMOVE, 31'h7FFFFFFF);
  endtask

  // fill to capacity, then full and duplicate-while-full cases, then drain
  task automatic test_fill_to_capacity();
    while (key_count < TABLE_DEPTH) send_request(OP_INSERT, KEY_W'($urandom()));
    send_request(OP_INSERT, KEY_W'($urandom()));
    send_request(OP_INSERT, key_table[10]);
    send_request(OP_INSERT, key_table[TABLE_DEPTH - 1]);
    send_request(OP_FIND, key_table[TABLE_DEPTH - 1]);
    send_request(OP_NONE, key_table[5]);
    send_request(OP_REMOVE, key_table[0]);
    send_request(OP_INSERT, KEY_W'($urandom()));
    send_request(OP_REMOVE, key_table[TABLE_DEPTH - 1]);
    send_request(OP_REMOVE, key_table[20]);
    while (key_count > 0) send_request(OP_REMOVE, key_table[$urandom_range(0, key_count - 1)]);
  endtask

  // table swings between growing toward full and shrinking toward empty
  task automatic test_random_traffic(input int count);
    bit grow;
    int roll;
    ukt_op_t op;
    grow = 1'b1;
    for (int n = 0; n < count; n++) begin
      calm = (n >= 500 && n < 700);
      roll = $urandom_range(0, 99);
      if (grow)
        op = ukt_op_t'(roll < 60 ? OP_INSERT : roll < 78 ? OP_FIND :
                       roll < 95 ? OP_REMOVE : OP_NONE);
      else
        op = ukt_op_t'(roll < 20 ? OP_INSERT : roll < 38 ? OP_FIND :
                       roll < 95 ? OP_REMOVE : OP_NONE);
      case (op)
        OP_INSERT: send_request(op, pick_key(15));
        OP_REMOVE: send_request(op, pick_key(grow ? 40 : 85));
        default:   send_request(op, pick_key(50));
      endcase
      if (key_count == TABLE_DEPTH && $urandom_range(0, 7) == 0) grow = 1'b0;
      if (key_count == 0) grow = 1'b1;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_edits();
    wait_for_replies();
    test_fill_to_capacity();
    wait_for_replies();
    test_random_traffic(1250);
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### unique_key_table_compacting.f
+incdir+hw/rtl
hw/rtl/ukt_pkg.sv
hw/rtl/ukt_cell.sv
hw/rtl/unique_key_table_compacting.sv
hw/rtl/ukt_checker.sv
bench/unique_key_table_compacting_tb.sv
